>>> src/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared definitions for the ordered list table
// Capacity, derived widths, operation codes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package olt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // common width for position / index / count compares
    localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;

    localparam int OP_W     = 2;
    localparam int POS_W    = 4;
    localparam int VAL_W    = 32;
    localparam int FPOS_W   = 4;
    localparam int OCNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    // control broadcast to every cell for one item
    typedef struct packed {
        logic             apply;   // operation accepted and allowed
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;   // entry count before the operation
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/ordered_list_table_core.sv
// ----------------------------------------------------------------------------
// ordered_list_table_core: ordered list of signed 32-bit values
// Append, insert, remove and find on a list of up to CAPACITY entries.
// ----------------------------------------------------------------------------
// Each input item carries one operation. The list lives in a row of cells,
// one entry per cell; insert and remove move every affected cell by one slot
// toward its neighbor in the same clock, and find compares all cells at once
// and takes the lowest hit. The result of an accepted item is loaded into
// the output register at the edge that accepts it, so the block sustains one
// item per clock as long as results are taken. A full list refuses append and
// insert, insert beyond the count and remove at or beyond the count are
// refused, all with ok low and the list unchanged. Entries hold no defined
// value after reset; only slots below the count are ever looked at.
`default_nettype none

module ordered_list_table_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // opcode[1:0], position[5:2], value[37:6], zero pad
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // ok[0], found_position[4:1], item_count[9:5], pad
);

    // item fields
    olt_pkg::op_t                      in_op;
    logic [olt_pkg::POS_W-1:0]         in_pos;
    logic signed [olt_pkg::VAL_W-1:0]  in_value;
    logic                              accept;

    assign in_op    = olt_pkg::op_t'(s_tdata[1:0]);
    assign in_pos   = s_tdata[5:2];
    assign in_value = s_tdata[37:6];

    // list count
    logic [olt_pkg::CNT_W-1:0] count_reg;
    logic [olt_pkg::CNT_W-1:0] count_next;

    // result register
    logic                       m_valid_reg;
    logic                       ok_reg;
    logic                       ok_next;
    logic [olt_pkg::FPOS_W-1:0] fpos_reg;
    logic [olt_pkg::FPOS_W-1:0] fpos_next;
    logic [olt_pkg::OCNT_W-1:0] ocnt_reg;

    // output slot free or being emptied this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // legality of the requested operation
    logic                       full;
    logic [olt_pkg::CMP_W-1:0]  pos_c;
    logic [olt_pkg::CMP_W-1:0]  cnt_c;
    logic                       allowed;
    logic                       any_match;
    logic [olt_pkg::IDX_W-1:0]  first_idx;

    assign full  = (olt_pkg::CMP_W'(count_reg) == olt_pkg::CMP_W'(olt_pkg::CAPACITY));
    assign pos_c = olt_pkg::CMP_W'(in_pos);
    assign cnt_c = olt_pkg::CMP_W'(count_reg);

    always_comb begin
        allowed    = 1'b0;
        ok_next    = 1'b0;
        fpos_next  = '0;
        count_next = count_reg;
        unique case (in_op)
            olt_pkg::OP_APPEND: begin
                allowed = !full;
                ok_next = allowed;
                if (allowed) begin
                    count_next = count_reg + 1'b1;
                end
            end
            olt_pkg::OP_INSERT: begin
                allowed = !full && (pos_c <= cnt_c);
                ok_next = allowed;
                if (allowed) begin
                    count_next = count_reg + 1'b1;
                end
            end
            olt_pkg::OP_REMOVE: begin
                allowed = (pos_c < cnt_c);
                ok_next = allowed;
                if (allowed) begin
                    count_next = count_reg - 1'b1;
                end
            end
            olt_pkg::OP_FIND: begin
                ok_next = any_match;
                if (any_match) begin
                    fpos_next = olt_pkg::FPOS_W'(first_idx);
                end
            end
            default: begin
                allowed = 1'b0;
            end
        endcase
    end

    // control shared by the whole cell row
    olt_pkg::cell_ctrl_t ctrl;

    assign ctrl.apply = accept && allowed;
    assign ctrl.op    = in_op;
    assign ctrl.pos   = in_pos;
    assign ctrl.count = count_reg;

    // row of cells; each sees its lower and upper neighbor
    logic signed [olt_pkg::VAL_W-1:0] entry [olt_pkg::CAPACITY];
    logic [olt_pkg::CAPACITY-1:0]     match;

    for (genvar g = 0; g < olt_pkg::CAPACITY; g++) begin : g_cell
        logic signed [olt_pkg::VAL_W-1:0] lower_entry;
        logic signed [olt_pkg::VAL_W-1:0] upper_entry;

        if (g == 0) begin : g_bottom
            assign lower_entry = entry[g];
        end else begin : g_lower
            assign lower_entry = entry[g-1];
        end

        // top cell has no upper neighbor; its slot drops out of the count anyway
        if (g == olt_pkg::CAPACITY - 1) begin : g_top
            assign upper_entry = entry[g];
        end else begin : g_upper
            assign upper_entry = entry[g+1];
        end

        olt_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_index  (olt_pkg::IDX_W'(g)),
            .value       (in_value),
            .lower_entry (lower_entry),
            .upper_entry (upper_entry),
            .entry       (entry[g]),
            .match       (match[g])
        );
    end

    olt_first_match u_first_match (
        .match (match),
        .any   (any_match),
        .index (first_idx)
    );

    // count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg   <= ok_next;
            fpos_reg <= fpos_next;
            ocnt_reg <= olt_pkg::OCNT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, ocnt_reg, fpos_reg, ok_reg};

endmodule

`default_nettype wire

>>> src/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell: one slot of the list
// Holds one entry, shifts with its neighbors and flags a find match.
// ----------------------------------------------------------------------------
`default_nettype none

module olt_cell (
    input  wire logic                            aclk,
    input  wire olt_pkg::cell_ctrl_t             ctrl,
    input  wire logic [olt_pkg::IDX_W-1:0]       cell_index,
    input  wire logic signed [olt_pkg::VAL_W-1:0] value,
    input  wire logic signed [olt_pkg::VAL_W-1:0] lower_entry,
    input  wire logic signed [olt_pkg::VAL_W-1:0] upper_entry,
    output logic signed [olt_pkg::VAL_W-1:0]      entry,
    output logic                                  match
);

    logic signed [olt_pkg::VAL_W-1:0] entry_reg;
    logic signed [olt_pkg::VAL_W-1:0] entry_next;
    logic                             entry_we;
    logic [olt_pkg::CMP_W-1:0]        idx_c;
    logic [olt_pkg::CMP_W-1:0]        pos_c;
    logic [olt_pkg::CMP_W-1:0]        cnt_c;

    assign idx_c = olt_pkg::CMP_W'(cell_index);
    assign pos_c = olt_pkg::CMP_W'(ctrl.pos);
    assign cnt_c = olt_pkg::CMP_W'(ctrl.count);

    always_comb begin
        entry_we   = 1'b0;
        entry_next = entry_reg;
        unique case (ctrl.op)
            olt_pkg::OP_APPEND: begin
                if (idx_c == cnt_c) begin
                    entry_we   = ctrl.apply;
                    entry_next = value;
                end
            end
            olt_pkg::OP_INSERT: begin
                if (idx_c == pos_c) begin
                    entry_we   = ctrl.apply;
                    entry_next = value;
                end else if (idx_c > pos_c) begin
                    entry_we   = ctrl.apply;
                    entry_next = lower_entry;
                end
            end
            olt_pkg::OP_REMOVE: begin
                if (idx_c >= pos_c) begin
                    entry_we   = ctrl.apply;
                    entry_next = upper_entry;
                end
            end
            olt_pkg::OP_FIND: begin
                entry_we = 1'b0;
            end
            default: begin
                entry_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    // only slots below the count hold live entries
    assign match = (entry_reg == value) && (idx_c < cnt_c);

endmodule

`default_nettype wire

>>> src/olt_first_match.sv
// ----------------------------------------------------------------------------
// olt_first_match: lowest matching slot
// Priority encoder over the match flags of the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module olt_first_match (
    input  wire logic [olt_pkg::CAPACITY-1:0] match,
    output logic                              any,
    output logic [olt_pkg::IDX_W-1:0]         index
);

    always_comb begin
        index = '0;
        for (int i = olt_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                index = olt_pkg::IDX_W'(i);
            end
        end
    end

    assign any = |match;

endmodule

`default_nettype wire
